@@ rtl/assert_macros.svh @@
// Assertion macros shared by the keyboard report builder RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check with reset masking.
`define HBK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check with no reset masking.
`define HBK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HBK_ASSERT(lbl, clk, rst_n, prop, msg)
`define HBK_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/hbk_pkg.sv @@
// Package for the boot keyboard report builder: constants, types, key code map.
// No dependencies.
`default_nettype none
package hbk_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int OUT_SLOTS = 6;
    localparam int MAP_AW    = 8;
    localparam int CNT_MAX   = KEY_SLOTS + 1;
    localparam int CNT_W     = $clog2(KEY_SLOTS + 2);

    localparam logic [4:0] EV_KEY      = 5'd1;
    localparam logic [1:0] KEY_RELEASE = 2'd0;
    localparam logic [1:0] KEY_PRESS   = 2'd1;

    localparam logic [7:0] MOD_FIRST  = 8'd224;
    localparam logic [7:0] MOD_LAST   = 8'd231;
    localparam logic [7:0] SCAN_FIRST = 8'd4;
    localparam logic [7:0] ADDR_LAST  = 8'hFF;
    localparam logic [7:0] ROLLOVER   = 8'd1;

    typedef struct packed {
        logic [7:0]                mods;
        logic [KEY_SLOTS-1:0][7:0] slots;
    } t_report;

    typedef struct packed {
        logic       clear;
        logic       valid;
        logic       held;
        logic [7:0] usage;
    } t_acc_ctl;

    // Key codes 0..127 to usage; 0 = unmapped or modifier.
    localparam logic [7:0] CODE_ROM [128] = '{
        8'd0,   8'd41,  8'd30,  8'd31,  8'd32,  8'd33,  8'd34,  8'd35,
        8'd36,  8'd37,  8'd38,  8'd39,  8'd45,  8'd46,  8'd42,  8'd43,
        8'd20,  8'd26,  8'd8,   8'd21,  8'd23,  8'd28,  8'd24,  8'd12,
        8'd18,  8'd19,  8'd47,  8'd48,  8'd40,  8'd0,   8'd4,   8'd22,
        8'd7,   8'd9,   8'd10,  8'd11,  8'd13,  8'd14,  8'd15,  8'd51,
        8'd52,  8'd53,  8'd0,   8'd49,  8'd29,  8'd27,  8'd6,   8'd25,
        8'd5,   8'd17,  8'd16,  8'd54,  8'd55,  8'd56,  8'd0,   8'd85,
        8'd0,   8'd44,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,
        8'd63,  8'd64,  8'd65,  8'd66,  8'd67,  8'd83,  8'd71,  8'd95,
        8'd96,  8'd97,  8'd86,  8'd92,  8'd93,  8'd94,  8'd87,  8'd89,
        8'd90,  8'd91,  8'd98,  8'd99,  8'd0,   8'd0,   8'd100, 8'd68,
        8'd69,  8'd135, 8'd0,   8'd0,   8'd138, 8'd136, 8'd139, 8'd140,
        8'd88,  8'd0,   8'd84,  8'd70,  8'd0,   8'd0,   8'd74,  8'd82,
        8'd75,  8'd80,  8'd79,  8'd77,  8'd81,  8'd78,  8'd73,  8'd76,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd102, 8'd103, 8'd0,   8'd72,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd137, 8'd0,   8'd0,   8'd101
    };

    // Key code to usage, modifiers to 224..231, F13..F24 block to 104..115.
    function automatic logic [7:0] usage_of(input logic [9:0] code);
        logic [7:0] u;
        u = 8'd0;
        if (code < 10'd128) begin
            u = CODE_ROM[code[6:0]];
        end else if (code >= 10'd183 && code <= 10'd194) begin
            u = 8'(code - 10'd79);
        end
        case (code)
            10'd29:  u = MOD_FIRST + 8'd0;
            10'd42:  u = MOD_FIRST + 8'd1;
            10'd56:  u = MOD_FIRST + 8'd2;
            10'd125: u = MOD_FIRST + 8'd3;
            10'd97:  u = MOD_FIRST + 8'd4;
            10'd54:  u = MOD_FIRST + 8'd5;
            10'd100: u = MOD_FIRST + 8'd6;
            10'd126: u = MOD_FIRST + 8'd7;
            default: u = u;
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

@@ rtl/hbk_map_ram.sv @@
// Generic one-write, one-read synchronous RAM, registered read data.
// No dependencies.
`default_nettype none
module hbk_map_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ rtl/hbk_report_acc.sv @@
// Report accumulator: folds scanned map bits into modifier mask and key slots.
// Depends on hbk_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module hbk_report_acc (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire hbk_pkg::t_acc_ctl i_ctl,
    output hbk_pkg::t_report      o_report
);

    logic [7:0]                        r_mods;
    logic [hbk_pkg::KEY_SLOTS-1:0][7:0] r_slots;
    logic [hbk_pkg::CNT_W-1:0]         r_count;
    logic                              is_mod;

    assign is_mod = i_ctl.usage inside {[hbk_pkg::MOD_FIRST:hbk_pkg::MOD_LAST]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.clear) begin
            r_count <= '0;
        end else if (i_ctl.valid && i_ctl.held && !is_mod) begin
            if (r_count <= hbk_pkg::CNT_W'(hbk_pkg::KEY_SLOTS)) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_mods  <= '0;
            r_slots <= '0;
        end else if (i_ctl.valid && i_ctl.held) begin
            if (is_mod) begin
                r_mods[i_ctl.usage[2:0]] <= 1'b1;
            end else begin
                for (int j = 0; j < hbk_pkg::KEY_SLOTS; j++) begin
                    if (r_count == hbk_pkg::CNT_W'(j)) begin
                        r_slots[j] <= i_ctl.usage;
                    end
                end
            end
        end
    end

    // More held keys than slots: every slot reports rollover.
    always_comb begin
        o_report.mods = r_mods;
        for (int j = 0; j < hbk_pkg::KEY_SLOTS; j++) begin
            o_report.slots[j] = (r_count > hbk_pkg::CNT_W'(hbk_pkg::KEY_SLOTS)) ?
                                hbk_pkg::ROLLOVER : r_slots[j];
        end
    end

    `HBK_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= hbk_pkg::CNT_W'(hbk_pkg::CNT_MAX), "key count ran past saturation")

endmodule
`default_nettype wire

@@ rtl/hid_boot_keyboard_report_builder_top.sv @@
// Top level of the boot keyboard report builder: sequencer, held-key map, report register.
// Depends on hbk_pkg, hbk_map_ram, hbk_report_acc and assert_macros.svh.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  events  | i_in_valid / o_in_ready, i_command ...   | in
//  reports | o_out_valid / i_out_ready, o_modifier... | out
//
// Ignored events (non-key type, autorepeat, unmapped code) are taken in S_IDLE,
// which they do not leave. A press or release writes the map, then S_SCAN reads
// usages 4..255 one per cycle from the single read port of the map RAM, S_LAST
// waits on the registered read data and S_FINISH does the compare. Release-all
// takes the accept, a sweep writing zeros to all 256 entries, then the compare stage.
// After reset a clearing pass zeroes the map; no item is taken then.
// A finished report waits in the output register while the next item is taken;
// the compare stage holds only if a new report meets a still-full register.
`default_nettype none
`include "assert_macros.svh"
module hid_boot_keyboard_report_builder_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_command,
    input  wire logic [4:0] i_event_type,
    input  wire logic [9:0] i_key_code,
    input  wire logic [1:0] i_key_value,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic      [7:0] o_modifier_bits,
    output logic      [7:0] o_key_slot_0,
    output logic      [7:0] o_key_slot_1,
    output logic      [7:0] o_key_slot_2,
    output logic      [7:0] o_key_slot_3,
    output logic      [7:0] o_key_slot_4,
    output logic      [7:0] o_key_slot_5
);

    typedef enum logic [2:0] {
        S_INIT,    // clearing pass after reset
        S_IDLE,    // waiting for an item
        S_CLEAR,   // release-all sweep
        S_SCAN,    // issuing map reads
        S_LAST,    // last read in flight
        S_FINISH   // compare and load output
    } t_state;

    t_state                              r_state;
    logic [hbk_pkg::MAP_AW-1:0]          r_addr;
    logic                                r_force;
    logic                                r_rd_valid;
    logic [7:0]                          r_rd_usage;
    logic                                r_out_valid;
    logic [7:0]                          r_out_mods;
    logic [hbk_pkg::OUT_SLOTS-1:0][7:0]  r_out_slots;
    hbk_pkg::t_report                    r_prev;

    logic                                in_accept;
    logic [7:0]                          ev_usage;
    logic                                ev_ok;
    logic                                ram_we;
    logic [hbk_pkg::MAP_AW-1:0]          ram_waddr;
    logic                                ram_wdata;
    logic                                ram_rdata;
    hbk_pkg::t_acc_ctl                   acc_ctl;
    hbk_pkg::t_report                    acc_report;
    logic                                emit;
    logic                                out_free;
    logic [hbk_pkg::OUT_SLOTS-1:0][7:0]  out_slots;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;

    // Event decode: only key press/release of a mapped code changes the map.
    assign ev_usage = hbk_pkg::usage_of(i_key_code);
    assign ev_ok    = !i_command && (i_event_type == hbk_pkg::EV_KEY) &&
                      (i_key_value inside {hbk_pkg::KEY_RELEASE, hbk_pkg::KEY_PRESS}) &&
                      (ev_usage != 8'd0);

    // Map write port: the event's own entry at accept, zeros during sweeps.
    // Writes and scan reads never share a cycle, so no forwarding is needed.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = 1'b0;
        if (r_state == S_INIT || r_state == S_CLEAR) begin
            ram_we = 1'b1;
        end else if (in_accept && ev_ok) begin
            ram_we    = 1'b1;
            ram_waddr = ev_usage;
            ram_wdata = i_key_value[0];
        end
    end

    hbk_map_ram #(
        .ADDR_W (hbk_pkg::MAP_AW),
        .DATA_W (1)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // Accumulator starts fresh on every accepted item.
    assign acc_ctl.clear = in_accept;
    assign acc_ctl.valid = r_rd_valid;
    assign acc_ctl.held  = ram_rdata;
    assign acc_ctl.usage = r_rd_usage;

    hbk_report_acc u_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (acc_ctl),
        .o_report (acc_report)
    );

    // Release-all always reports; otherwise only a changed report goes out.
    assign emit     = r_force || (acc_report != r_prev);
    assign out_free = !r_out_valid || i_out_ready;

    // Slots past KEY_SLOTS read zero on the port.
    always_comb begin
        for (int j = 0; j < hbk_pkg::OUT_SLOTS; j++) begin
            out_slots[j] = (j < hbk_pkg::KEY_SLOTS) ?
                           acc_report.slots[j % hbk_pkg::KEY_SLOTS] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_force     <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
        end else begin
            r_rd_valid <= (r_state == S_SCAN);
            r_rd_usage <= r_addr;
            // A report loaded in S_FINISH replaces the one leaving this cycle.
            if (r_out_valid && i_out_ready && !(r_state == S_FINISH && emit)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == hbk_pkg::ADDR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        if (i_command) begin
                            r_force <= 1'b1;
                            r_addr  <= '0;
                            r_state <= S_CLEAR;
                        end else if (ev_ok) begin
                            r_force <= 1'b0;
                            r_addr  <= hbk_pkg::SCAN_FIRST;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == hbk_pkg::ADDR_LAST) begin
                        r_state <= S_FINISH;
                    end
                end
                S_SCAN: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == hbk_pkg::ADDR_LAST) begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!emit) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_mods  <= acc_report.mods;
                        r_out_slots <= out_slots;
                        r_prev      <= acc_report;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_modifier_bits = r_out_mods;
    assign o_key_slot_0    = r_out_slots[0];
    assign o_key_slot_1    = r_out_slots[1];
    assign o_key_slot_2    = r_out_slots[2];
    assign o_key_slot_3    = r_out_slots[3];
    assign o_key_slot_4    = r_out_slots[4];
    assign o_key_slot_5    = r_out_slots[5];

    `HBK_ASSERT(a_no_write_in_scan, i_clk, i_rst_n, (r_state == S_SCAN) |-> !ram_we, "map written during scan")
    `HBK_ASSERT(a_out_matches_prev, i_clk, i_rst_n, r_out_valid |-> (r_out_mods == r_prev.mods), "pending report differs from stored report")
    `HBK_ASSERT(a_release_sweeps, i_clk, i_rst_n, (in_accept && i_command) |=> (r_state == S_CLEAR), "release-all did not start sweep")

endmodule
`default_nettype wire

@@ test/hid_boot_keyboard_report_builder_top_tb.sv @@
// Testbench for hid_boot_keyboard_report_builder_top: key events in, boot reports out.
// Depends on hbk_pkg and the RTL under rtl/; self-checking through a report tracker class.
`timescale 1ns / 100ps

localparam logic       CMD_KEY_EVENT   = 1'b0;
localparam logic       CMD_RELEASE_ALL = 1'b1;
localparam logic [1:0] KEY_REPEAT      = 2'd2;
localparam logic [1:0] KEY_UNDEFINED   = 2'd3;
localparam int         SLOT_CAP        = 14;

typedef struct packed {
    logic [7:0]      mods;
    logic [5:0][7:0] slots;
} t_kbd_report;

// Tracks the held-usage map and the last report; queues the reports due.
class kbd_report_tracker;
    logic [255:0] held;
    logic [7:0]   last_mods;
    logic [7:0]   last_slots [SLOT_CAP];
    logic [7:0]   code_map [128];
    logic [9:0]   mod_codes [8];
    int           slot_total;
    t_kbd_report  reports_due [$];
    int unsigned  mismatches;

    function new();
        held        = '0;
        last_mods   = '0;
        mismatches  = 0;
        foreach (last_slots[j]) last_slots[j] = '0;
        slot_total  = hbk_pkg::KEY_SLOTS;
        if (slot_total < 1) slot_total = 1;
        if (slot_total > SLOT_CAP) slot_total = SLOT_CAP;
        // left ctrl, left shift, left alt, left meta, right ctrl, right shift, right alt, right meta
        mod_codes = '{10'd29, 10'd42, 10'd56, 10'd125, 10'd97, 10'd54, 10'd100, 10'd126};
        code_map = '{
            0,   41,  30,  31,  32,  33,  34,  35,  36,  37,  38,  39,  45,  46,  42,  43,
            20,  26,  8,   21,  23,  28,  24,  12,  18,  19,  47,  48,  40,  0,   4,   22,
            7,   9,   10,  11,  13,  14,  15,  51,  52,  53,  0,   49,  29,  27,  6,   25,
            5,   17,  16,  54,  55,  56,  0,   85,  0,   44,  57,  58,  59,  60,  61,  62,
            63,  64,  65,  66,  67,  83,  71,  95,  96,  97,  86,  92,  93,  94,  87,  89,
            90,  91,  98,  99,  0,   0,   100, 68,  69,  135, 0,   0,   138, 136, 139, 140,
            88,  0,   84,  70,  0,   0,   74,  82,  75,  80,  79,  77,  81,  78,  73,  76,
            0,   0,   0,   0,   102, 103, 0,   72,  0,   0,   0,   0,   137, 0,   0,   101
        };
    endfunction

    function logic [7:0] usage_for(logic [9:0] code);
        for (int m = 0; m < 8; m++) begin
            if (code == mod_codes[m]) return hbk_pkg::MOD_FIRST + 8'(m);
        end
        if (code < 10'd128) return code_map[code[6:0]];
        // F13..F24 sit in a block of their own
        if (code >= 10'd183 && code <= 10'd194) return 8'd104 + 8'(code - 10'd183);
        return 8'd0;
    endfunction

    function int pending();
        return reports_due.size();
    endfunction

    task flag(string what);
        mismatches++;
        $display("[%0t] report error: %s", $time, what);
    endtask

    // Rescan the map; queue a report if it changed or if forced.
    function void rescan(bit forced);
        logic [7:0]  mods;
        logic [7:0]  fresh [SLOT_CAP];
        int          found;
        bit          same;
        t_kbd_report rep;
        mods  = '0;
        found = 0;
        foreach (fresh[j]) fresh[j] = '0;
        for (int u = hbk_pkg::SCAN_FIRST; u < 256; u++) begin
            if (held[u]) begin
                if (u >= hbk_pkg::MOD_FIRST && u <= hbk_pkg::MOD_LAST) begin
                    mods[u - hbk_pkg::MOD_FIRST] = 1'b1;
                end else begin
                    if (found < slot_total) fresh[found] = 8'(u);
                    if (found <= slot_total) found++;
                end
            end
        end
        if (found > slot_total) begin
            for (int j = 0; j < slot_total; j++) fresh[j] = hbk_pkg::ROLLOVER;
        end
        same = (mods == last_mods);
        foreach (fresh[j]) if (fresh[j] != last_slots[j]) same = 1'b0;
        if (same && !forced) return;
        last_mods  = mods;
        last_slots = fresh;
        rep.mods = mods;
        for (int j = 0; j < 6; j++) rep.slots[j] = (j < slot_total) ? fresh[j] : 8'd0;
        reports_due.push_back(rep);
    endfunction

    function void take_event(logic cmd, logic [4:0] etype, logic [9:0] code, logic [1:0] value);
        logic [7:0] u;
        if (cmd == CMD_RELEASE_ALL) begin
            held = '0;
            rescan(1'b1);
            return;
        end
        if (etype != hbk_pkg::EV_KEY || value > hbk_pkg::KEY_PRESS) return;
        u = usage_for(code);
        if (u == 8'd0) return;
        held[u] = value[0];
        rescan(1'b0);
    endfunction

    task match_report(t_kbd_report got);
        t_kbd_report want;
        if (reports_due.size() == 0) begin
            flag($sformatf("report with none due: mods=%h slots=%h", got.mods, got.slots));
            return;
        end
        want = reports_due.pop_front();
        if (got.mods != want.mods)
            flag($sformatf("modifier_bits got %h want %h", got.mods, want.mods));
        for (int j = 0; j < 6; j++) begin
            if (got.slots[j] != want.slots[j])
                flag($sformatf("key_slot_%0d got %0d want %0d", j, got.slots[j], want.slots[j]));
        end
    endtask
endclass

module hid_boot_keyboard_report_builder_top_tb;

    localparam int unsigned ITEM_COUNT    = 1900;       // items offered in the random part
    localparam int unsigned SETTLE_CYCLES = 300;        // outlasts a release-all sweep
    localparam int unsigned CYCLE_LIMIT   = 6_000_000;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic       i_command    = 1'b0;
    logic [4:0] i_event_type = '0;
    logic [9:0] i_key_code   = '0;
    logic [1:0] i_key_value  = '0;
    logic       i_out_ready  = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_modifier_bits;
    logic [7:0] o_key_slot_0, o_key_slot_1, o_key_slot_2;
    logic [7:0] o_key_slot_3, o_key_slot_4, o_key_slot_5;

    kbd_report_tracker tracker;
    logic              steady = 1'b0;     // both sides stop idling while set
    int unsigned       stall_left = 0;
    int unsigned       cycle_count = 0;

    hid_boot_keyboard_report_builder_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_event_type    (i_event_type),
        .i_key_code      (i_key_code),
        .i_key_value     (i_key_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_modifier_bits (o_modifier_bits),
        .o_key_slot_0    (o_key_slot_0),
        .o_key_slot_1    (o_key_slot_1),
        .o_key_slot_2    (o_key_slot_2),
        .o_key_slot_3    (o_key_slot_3),
        .o_key_slot_4    (o_key_slot_4),
        .o_key_slot_5    (o_key_slot_5)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Report side: mostly ready, short stalls, and now and then a stall long
    // enough to back up the compare stage behind a full output register.
    always @(posedge i_clk) begin : report_sink
        int unsigned pick;
        pick = $urandom_range(0, 9999);
        if (steady) begin
            stall_left = 0;
            i_out_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (pick < 2) begin
            stall_left = $urandom_range(260, 600);
            i_out_ready <= 1'b0;
        end else if (pick < 202) begin
            stall_left = $urandom_range(0, 5);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Outputs are sampled at the falling edge, where they hold the values the
    // next rising edge will see; a transfer happens at that rising edge.
    always @(negedge i_clk) begin : report_watch
        t_kbd_report got;
        if (tracker != null && i_rst_n && o_out_valid && i_out_ready) begin
            got.mods     = o_modifier_bits;
            got.slots[0] = o_key_slot_0;
            got.slots[1] = o_key_slot_1;
            got.slots[2] = o_key_slot_2;
            got.slots[3] = o_key_slot_3;
            got.slots[4] = o_key_slot_4;
            got.slots[5] = o_key_slot_5;
            tracker.match_report(got);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Presents one item and returns at the rising edge that takes it. Valid is
    // left high; the caller either offers the next item in the same step or
    // drops valid.
    task automatic offer_event(logic cmd, logic [4:0] etype, logic [9:0] code,
                               logic [1:0] value);
        bit took;
        if (!steady && $urandom_range(0, 99) < 15) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 300)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_event_type <= etype;
        i_key_code   <= code;
        i_key_value  <= value;
        do begin
            @(negedge i_clk);
            took = o_in_ready;
            @(posedge i_clk);
        end while (!took);
        tracker.take_event(cmd, etype, code, value);
    endtask

    // Hold off the sender until every report due has come out.
    task automatic drain_reports();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [9:0] any_mapped_code();
        int unsigned pick;
        logic [9:0]  code;
        pick = $urandom_range(0, 99);
        if (pick < 20) return tracker.mod_codes[$urandom_range(0, 7)];
        if (pick < 35) return 10'($urandom_range(183, 194));
        do code = 10'($urandom_range(1, 127)); while (tracker.usage_for(code) == 8'd0);
        return code;
    endfunction

    initial begin : stimulus
        logic        cmd;
        logic [4:0]  etype;
        logic [9:0]  code;
        logic [1:0]  value;
        logic [9:0]  down_codes [$];
        int unsigned item_total;
        int unsigned pick;
        int unsigned idx;
        bit          paused;
        bit          known;

        tracker    = new();
        item_total = 0;
        paused     = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part ----
        // release-all on an empty map still reports
        offer_event(CMD_RELEASE_ALL, 5'd0, 10'd0, hbk_pkg::KEY_RELEASE);
        // code 30 is usage 4, the first usage scanned
        offer_event(CMD_KEY_EVENT, hbk_pkg::EV_KEY, 10'd30, hbk_pkg::KEY_PRESS);
        // autorepeat and the undefined value are dropped
        offer_event(CMD_KEY_EVENT, hbk_pkg::EV_KEY, 10'd30, KEY_REPEAT);
        offer_event(CMD_KEY_EVENT, hbk_pkg::EV_KEY, 10'd30, KEY_UNDEFINED);
        // event types other than key are dropped, lowest and highest
        offer_event(CMD_KEY_EVENT, 5'd0, 10'd30, hbk_pkg::KEY_PRESS);
        offer_event(CMD_KEY_EVENT, 5'd31, 10'd767, hbk_pkg::KEY_PRESS);
        // codes with no usage: zero, a hole in the table, just past it, the top
        offer_event(CMD_KEY_EVENT, hbk_pkg::EV_KEY, 10'd0, hbk_pkg::KEY_PRESS);
        offer_event(CMD_KEY_EVENT, hbk_pkg::EV_KEY, 10'd84, hbk_pkg::KEY_PRESS);
        offer_event(CMD_KEY_EVENT, hbk_pkg::EV_KEY, 10'd128, hbk_pkg::KEY_PRESS);
        offer_event(CMD_KEY_EVENT, hbk_pkg::EV_KEY, 10'd767, hbk_pkg::KEY_PRESS);
        // lowest and highest modifier bits
        offer_event(CMD_KEY_EVENT, hbk_pkg::EV_KEY, 10'd29, hbk_pkg::KEY_PRESS);
        offer_event(CMD_KEY_EVENT, hbk_pkg::EV_KEY, 10'd126, hbk_pkg::KEY_PRESS);
        // both ends of the F13..F24 block
        offer_event(CMD_KEY_EVENT, hbk_pkg::EV_KEY, 10'd183, hbk_pkg::KEY_PRESS);
        offer_event(CMD_KEY_EVENT, hbk_pkg::EV_KEY, 10'd194, hbk_pkg::KEY_PRESS);
        // fill all six slots, then a seventh key trips rollover
        offer_event(CMD_KEY_EVENT, hbk_pkg::EV_KEY, 10'd2, hbk_pkg::KEY_PRESS);
        offer_event(CMD_KEY_EVENT, hbk_pkg::EV_KEY, 10'd3, hbk_pkg::KEY_PRESS);
        offer_event(CMD_KEY_EVENT, hbk_pkg::EV_KEY, 10'd4, hbk_pkg::KEY_PRESS);
        offer_event(CMD_KEY_EVENT, hbk_pkg::EV_KEY, 10'd5, hbk_pkg::KEY_PRESS);
        // an eighth key leaves the rollover report as it was
        offer_event(CMD_KEY_EVENT, hbk_pkg::EV_KEY, 10'd6, hbk_pkg::KEY_PRESS);
        // back down to seven (still rollover), then six
        offer_event(CMD_KEY_EVENT, hbk_pkg::EV_KEY, 10'd5, hbk_pkg::KEY_RELEASE);
        offer_event(CMD_KEY_EVENT, hbk_pkg::EV_KEY, 10'd6, hbk_pkg::KEY_RELEASE);
        // press of a key already down: nothing changes
        offer_event(CMD_KEY_EVENT, hbk_pkg::EV_KEY, 10'd2, hbk_pkg::KEY_PRESS);
        // release-all ignores the other fields; twice in a row both report
        offer_event(CMD_RELEASE_ALL, hbk_pkg::EV_KEY, 10'd30, hbk_pkg::KEY_PRESS);
        offer_event(CMD_RELEASE_ALL, 5'd31, 10'd767, KEY_UNDEFINED);
        drain_reports();

        // ---- random part ----
        // Mostly plausible typing: presses and releases of mapped keys with the
        // held count kept around the rollover threshold. About a fifth of the
        // items are noise that the block should drop or find unchanged.
        while (item_total < ITEM_COUNT) begin
            steady <= (item_total >= 700 && item_total < 1000);
            pick = $urandom_range(0, 99);
            cmd  = CMD_KEY_EVENT;
            if (pick < 20) begin
                etype = hbk_pkg::EV_KEY;
                case ($urandom_range(0, 3))
                    0: begin
                        // anything but a key event
                        etype = 5'($urandom_range(0, 30));
                        if (etype >= hbk_pkg::EV_KEY) etype = etype + 5'd1;
                        code  = 10'($urandom_range(0, 767));
                        value = 2'($urandom_range(0, 3));
                    end
                    1: begin
                        code  = any_mapped_code();
                        value = ($urandom_range(0, 1) != 0) ? KEY_REPEAT : KEY_UNDEFINED;
                    end
                    2: begin
                        do code = 10'($urandom_range(0, 767));
                        while (tracker.usage_for(code) != 8'd0);
                        value = 2'($urandom_range(0, 1));
                    end
                    default: begin
                        // press again of a key that is already down
                        if (down_codes.size() != 0) begin
                            code  = down_codes[$urandom_range(0, down_codes.size() - 1)];
                            value = hbk_pkg::KEY_PRESS;
                        end else begin
                            code  = any_mapped_code();
                            value = KEY_REPEAT;
                        end
                    end
                endcase
            end else if (pick < 23) begin
                cmd   = CMD_RELEASE_ALL;
                etype = 5'($urandom_range(0, 31));
                code  = 10'($urandom_range(0, 767));
                value = 2'($urandom_range(0, 3));
                down_codes.delete();
            end else if (down_codes.size() < 2 ||
                         (down_codes.size() < 9 && $urandom_range(0, 99) < 55)) begin
                etype = hbk_pkg::EV_KEY;
                code  = any_mapped_code();
                value = hbk_pkg::KEY_PRESS;
                known = 1'b0;
                foreach (down_codes[k]) if (down_codes[k] == code) known = 1'b1;
                if (!known) down_codes.push_back(code);
            end else begin
                etype = hbk_pkg::EV_KEY;
                idx   = $urandom_range(0, down_codes.size() - 1);
                code  = down_codes[idx];
                value = hbk_pkg::KEY_RELEASE;
                down_codes.delete(idx);
            end

            offer_event(cmd, etype, code, value);
            item_total++;

            // one mid-run hold-off with the pipeline fully drained
            if (!paused && item_total >= 1200) begin
                paused = 1'b1;
                drain_reports();
            end
        end

        steady <= 1'b0;
        drain_reports();
        if (tracker.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
